// ===== rtl/vsm_pkg.sv =====
// Shared types, constants and the exponential table for the vector softmax block.
package vsm_pkg;

	// Sequencer states
	typedef enum logic [2:0] {
		ST_LOAD,
		ST_EXP_RD,
		ST_EXP_CALC,
		ST_EXP_WR,
		ST_DIV_RD,
		ST_DIV_RUN,
		ST_OUT
	} vsm_state_t;

	localparam int unsigned ELEM_W  = 16;
	localparam int unsigned EXP_W   = 17;
	localparam int unsigned SUM_W   = 23;
	localparam int unsigned PROB_W  = 16;
	localparam int unsigned DIVQ_W  = 17;
	localparam int unsigned EXP_LN2 = 369;
	localparam logic signed [17:0] EXP_FLOOR = -18'sd4096;

	// 2^(-k/16) in Q1.16, rounded
	function automatic logic [EXP_W-1:0] pow2_frac(input logic [3:0] k);
		logic [EXP_W-1:0] r;
		begin
			case (k)
				4'd0:    r = 17'd65536;
				4'd1:    r = 17'd62757;
				4'd2:    r = 17'd60097;
				4'd3:    r = 17'd57549;
				4'd4:    r = 17'd55109;
				4'd5:    r = 17'd52773;
				4'd6:    r = 17'd50535;
				4'd7:    r = 17'd48393;
				4'd8:    r = 17'd46341;
				4'd9:    r = 17'd44376;
				4'd10:   r = 17'd42495;
				4'd11:   r = 17'd40693;
				4'd12:   r = 17'd38968;
				4'd13:   r = 17'd37316;
				4'd14:   r = 17'd35734;
				4'd15:   r = 17'd34219;
				default: r = 17'd0;
			endcase
			return r;
		end
	endfunction

endpackage

// ===== rtl/vsm_exp.sv =====
// Registered exponential approximation: exp(x - max) in Q1.16.
module vsm_exp import vsm_pkg::*; (
	input  logic                     clk,
	input  logic signed [ELEM_W-1:0] elem,
	input  logic signed [ELEM_W-1:0] max_val,
	output logic        [EXP_W-1:0]  exp_q
);
	logic signed [17:0] diff;
	logic [12:0] mag;
	logic [21:0] prod;
	logic [13:0] y;
	logic [EXP_W-1:0] res;

	// difference, clamp, scale by log2(e), table and shift
	always_comb begin
		diff = 18'(elem) - 18'(max_val);
		if (diff > 18'sd0) diff = 18'sd0;
		mag  = 13'(-diff);
		prod = 22'(mag) * 22'(EXP_LN2);
		y    = prod[21:8];
		if (diff < EXP_FLOOR) res = '0;
		else res = pow2_frac(y[7:4]) >> y[13:8];
	end

	always_ff @(posedge clk) begin
		exp_q <= res;
	end
endmodule

// ===== rtl/vsm_div.sv =====
// Restoring divider, one quotient bit per cycle: (num*65536 + den/2) / den.
module vsm_div import vsm_pkg::*; (
	input  logic                   clk,
	input  logic                   arst_n,
	input  logic                   start,
	input  logic [EXP_W-1:0]       num,
	input  logic [SUM_W-1:0]       den,
	output logic                   done,
	output logic [PROB_W-1:0]      quot
);
	localparam int unsigned DIV_W = EXP_W + 16;
	localparam int unsigned CNT_W = $clog2(DIV_W + 1);

	logic [DIV_W-1:0] dvd_q;
	logic [SUM_W:0]   rem_q;
	logic [DIV_W-1:0] quo_q;
	logic [SUM_W-1:0] den_q;
	logic [CNT_W-1:0] cnt_q;
	logic             busy_q;
	logic [SUM_W:0]   trial;

	assign trial = {rem_q[SUM_W-1:0], dvd_q[DIV_W-1]};

	// one shift-subtract step per cycle
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_W'(DIV_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_W'(1)) busy_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= {num, 16'd0} + DIV_W'(den >> 1);
			rem_q <= '0;
			quo_q <= '0;
			den_q <= den;
		end else if (busy_q) begin
			dvd_q <= dvd_q << 1;
			if (trial >= {1'b0, den_q}) begin
				rem_q <= trial - {1'b0, den_q};
				quo_q <= {quo_q[DIV_W-2:0], 1'b1};
			end else begin
				rem_q <= trial;
				quo_q <= {quo_q[DIV_W-2:0], 1'b0};
			end
		end
	end

	assign done = busy_q && (cnt_q == CNT_W'(1));
	// next quotient bit folded in on the final step, then saturated; zero for a zero divisor
	logic [DIV_W-1:0] qfin;
	assign qfin = {quo_q[DIV_W-2:0], (trial >= {1'b0, den_q})};
	assign quot = (den_q == '0) ? '0 :
		((qfin > DIV_W'(65535)) ? 16'hFFFF : qfin[PROB_W-1:0]);
endmodule

// ===== rtl/vsm_ctrl.sv =====
// Sequencer, element/exponential stores, running max and sum.
module vsm_ctrl import vsm_pkg::*; #(
	parameter int unsigned MAX_LENGTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic signed [ELEM_W-1:0] sample_value,
	input  logic                     final_element,
	input  logic                     in_valid,
	output logic                     in_ready,
	output logic [PROB_W-1:0]        probability,
	output logic                     final_result,
	output logic                     out_valid,
	input  logic                     out_ready
);
	localparam int unsigned IDX_W = $clog2(MAX_LENGTH);
	localparam int unsigned CNT_W = $clog2(MAX_LENGTH + 1);

	vsm_state_t state_q, state_d;

	logic signed [ELEM_W-1:0] elem_mem [MAX_LENGTH];
	logic        [EXP_W-1:0]  exp_mem  [MAX_LENGTH];
	logic signed [ELEM_W-1:0] elem_rd_q;
	logic        [EXP_W-1:0]  exp_rd_q;
	logic signed [ELEM_W-1:0] max_q;
	logic [SUM_W-1:0] sum_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CNT_W-1:0] ptr_q;
	logic [EXP_W-1:0] exp_val;
	logic             div_start, div_done;
	logic             div_first_q;
	logic [PROB_W-1:0] quot;
	logic             acc, ptr_last, out_take;

	assign acc      = in_valid && in_ready;
	assign ptr_last = (ptr_q + 1'b1) == cnt_q;
	assign out_take = out_valid && out_ready;

	// next state
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_LOAD:    if (acc && (final_element || cnt_q == CNT_W'(MAX_LENGTH - 1)))
				state_d = ST_EXP_RD;
			ST_EXP_RD:   state_d = ST_EXP_CALC;
			ST_EXP_CALC: state_d = ST_EXP_WR;
			ST_EXP_WR:   state_d = ptr_last ? ST_DIV_RD : ST_EXP_RD;
			ST_DIV_RD:   state_d = ST_DIV_RUN;
			ST_DIV_RUN:  if (div_done) state_d = ST_OUT;
			ST_OUT:      if (out_take) state_d = ptr_last ? ST_LOAD : ST_DIV_RD;
			default:     state_d = ST_LOAD;
		endcase
	end

	// outputs; divider starts on the first cycle of ST_DIV_RUN
	always_comb begin
		in_ready  = (state_q == ST_LOAD);
		out_valid = (state_q == ST_OUT);
		div_start = (state_q == ST_DIV_RUN) && div_first_q;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			max_q       <= '0;
			sum_q       <= '0;
			cnt_q       <= '0;
			ptr_q       <= '0;
			div_first_q <= 1'b0;
		end else begin
			state_q     <= state_d;
			div_first_q <= (state_q == ST_DIV_RD);
			case (state_q)
				ST_LOAD: if (acc) begin
					if (cnt_q == '0 || sample_value > max_q) max_q <= sample_value;
					cnt_q <= cnt_q + 1'b1;
					ptr_q <= '0;
					sum_q <= '0;
				end
				ST_EXP_WR: begin
					sum_q <= sum_q + SUM_W'(exp_val);
					ptr_q <= ptr_last ? '0 : ptr_q + 1'b1;
				end
				ST_OUT: if (out_take) begin
					ptr_q <= ptr_q + 1'b1;
					if (ptr_last) begin
						max_q <= '0;
						sum_q <= '0;
						cnt_q <= '0;
					end
				end
				default: ;
			endcase
		end
	end

	// stores, registered reads
	always_ff @(posedge clk) begin
		if (acc) elem_mem[cnt_q[IDX_W-1:0]] <= sample_value;
		if (state_q == ST_EXP_WR) exp_mem[ptr_q[IDX_W-1:0]] <= exp_val;
		elem_rd_q <= elem_mem[ptr_q[IDX_W-1:0]];
		exp_rd_q  <= exp_mem[ptr_q[IDX_W-1:0]];
	end

	vsm_exp u_exp (
		.clk     (clk),
		.elem    (elem_rd_q),
		.max_val (max_q),
		.exp_q   (exp_val)
	);

	vsm_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start),
		.num    (exp_rd_q),
		.den    (sum_q),
		.done   (div_done),
		.quot   (quot)
	);

	logic [PROB_W-1:0] prob_q;
	always_ff @(posedge clk) begin
		if (div_done) prob_q <= quot;
	end
	assign probability  = prob_q;
	assign final_result = ptr_last;
endmodule

// ===== rtl/vector_softmax_top.sv =====
// Top level of the vector softmax block.
//  channel | signals                                   | direction
//  input   | in_valid in_ready sample_value final_element | into block
//  output  | out_valid out_ready probability final_result | out of block
// Loading accepts one element per cycle while in_valid is high. After the last
// element, each element passes through the exponential pass (read, calculate,
// write), then through the shared restoring divider (read, start, steps, output)
// plus the wait on out_ready. Reset clears control state only; the stores hold
// no reset value. Input is refused while a vector is being computed or emitted;
// output stalls hold the result register.
module vector_softmax_top import vsm_pkg::*; #(
	parameter int unsigned MAX_LENGTH = 64
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     in_valid,
	output logic                     in_ready,
	input  logic signed [ELEM_W-1:0] sample_value,
	input  logic                     final_element,
	output logic                     out_valid,
	input  logic                     out_ready,
	output logic [PROB_W-1:0]        probability,
	output logic                     final_result
);
	vsm_ctrl #(.MAX_LENGTH(MAX_LENGTH)) u_ctrl (
		.clk           (clk),
		.arst_n        (arst_n),
		.sample_value  (sample_value),
		.final_element (final_element),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.probability   (probability),
		.final_result  (final_result),
		.out_valid     (out_valid),
		.out_ready     (out_ready)
	);
endmodule

// ===== rtl/vsm_checker.sv =====
// Port-level checker for the vector softmax block, bound to the top level.
module vsm_checker import vsm_pkg::*; (
	input logic              clk,
	input logic              arst_n,
	input logic              in_valid,
	input logic              in_ready,
	input logic              out_valid,
	input logic              out_ready,
	input logic [PROB_W-1:0] probability,
	input logic              final_result
);
	// no input taken while a result is offered
	a_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(in_ready && out_valid)) else $error("in_ready with out_valid");
	// a stalled result holds
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(probability))
		else $error("result dropped");
	// a waiting request stays offered
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_ready |=> in_valid)
		else $error("request withdrawn");
	// after the final result, block returns to loading
	a_back: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready && final_result |=> in_ready)
		else $error("not back to load");
	// after reset block is loading
	a_rst: assert property (@(posedge clk) $rose(arst_n) |-> in_ready)
		else $error("not ready after reset");
endmodule

bind vector_softmax_top vsm_checker u_vsm_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_valid),
	.in_ready     (in_ready),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.probability  (probability),
	.final_result (final_result)
);
